### rtl/textured_span_rasterizer_unit_defines.svh
// Assertion helpers shared by the rasterizer RTL.
// Both macros expect a signal named clk in the calling module; TSR_ASSERT also expects rst.
`ifndef TEXTURED_SPAN_RASTERIZER_UNIT_DEFINES_SVH
`define TEXTURED_SPAN_RASTERIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSR_ASSERT(lbl, prop, msg)
`define TSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/tsr_pkg.sv
`default_nettype none
package tsr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int DIV_NUM_W   = 49;

  localparam logic [6:0] MAX_WIDTH  = 7'd64;
  localparam logic [6:0] MAX_HEIGHT = 7'd64;

  localparam logic signed [31:0] FAR_DEPTH = 32'sh7FFF_FFFF;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  // One span after classification: ends in left-to-right order, clipped.
  typedef struct packed {
    logic [5:0]         row;
    logic [5:0]         xa;
    logic [6:0]         n;
    logic               persp;
    logic signed [31:0] z0;
    logic signed [31:0] z1;
    logic signed [31:0] uz0;
    logic signed [31:0] uz1;
    logic signed [31:0] vz0;
    logic signed [31:0] vz1;
    logic signed [31:0] iz0;
    logic signed [31:0] iz1;
  } span_t;

  typedef struct packed {
    logic [5:0]         x;
    logic [5:0]         y;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] depth;
    logic               we;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic                           start;
    logic signed [DIV_NUM_W-1:0]    num;
    logic signed [31:0]             den;
    logic                           short_mode;
    logic                           sat;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic [6:0] eff_dim(input logic [6:0] v, input logic [6:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage
`default_nettype wire

### rtl/textured_span_rasterizer_unit.sv
`default_nettype none
// Perspective-correct span rasterizer with a 64 by 64 depth buffer. Each word pushed in is one
// horizontal span; each word popped out is one covered pixel, left to right, with its column,
// row, texture u and v, interpolated depth, a write flag from the depth test and a flag on
// the last pixel. After reset the depth buffer is filled with the far value by a pass over all 4096
// words, during which full stays high. Each span then gets a setup of four 33-step divisions in
// perspective mode or four 48-step and three 33-step divisions in affine mode, all on one shared
// bit-serial divider. Each pixel then passes through the states S_PIX and S_TEST in affine mode; in
// perspective mode S_RWAIT, S_MULU and S_MULV come between them, and in S_RWAIT the divider forms
// the per-pixel reciprocal of 1/z. Rejected spans produce nothing.
module textured_span_rasterizer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] row,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] start_depth,
  input  wire logic signed [31:0] end_depth,
  input  wire logic signed [31:0] start_u_over_z,
  input  wire logic signed [31:0] end_u_over_z,
  input  wire logic signed [31:0] start_v_over_z,
  input  wire logic signed [31:0] end_v_over_z,
  input  wire logic signed [31:0] start_inv_z,
  input  wire logic signed [31:0] end_inv_z,
  input  wire logic               perspective_mode,
  output logic                    empty,
  input  wire logic               pop,
  output logic [5:0]              pixel_x,
  output logic [5:0]              pixel_y,
  output logic signed [31:0]      tex_u,
  output logic signed [31:0]      tex_v,
  output logic signed [31:0]      pixel_depth,
  output logic                    write_enable,
  output logic                    last_pixel,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);

  // Screen size registers. Values above the buffer size act as the buffer size.
  logic [6:0] screen_width;
  logic [6:0] screen_height;
  logic [6:0] width_eff;
  logic [6:0] height_eff;

  // Front to back span queue.
  logic           sq_push;
  logic           sq_pop;
  logic           sq_full;
  logic           sq_empty;
  tsr_pkg::span_t sq_entry;
  tsr_pkg::span_t sq_head;

  logic            clearing;
  tsr_pkg::pixel_t res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tsr_pkg::MAX_WIDTH;
      screen_height <= tsr_pkg::MAX_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index[0])
        tsr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        tsr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default:                    screen_width  <= cfg_data;
      endcase
    end
  end

  assign width_eff  = tsr_pkg::eff_dim(screen_width, tsr_pkg::MAX_WIDTH);
  assign height_eff = tsr_pkg::eff_dim(screen_height, tsr_pkg::MAX_HEIGHT);

  // The front swaps reversed ends, rejects off-screen rows and clips x to pixel centres.
  tsr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .hold             (clearing),
    .row              (row),
    .start_x          (start_x),
    .end_x            (end_x),
    .start_depth      (start_depth),
    .end_depth        (end_depth),
    .start_u_over_z   (start_u_over_z),
    .end_u_over_z     (end_u_over_z),
    .start_v_over_z   (start_v_over_z),
    .end_v_over_z     (end_v_over_z),
    .start_inv_z      (start_inv_z),
    .end_inv_z        (end_inv_z),
    .perspective_mode (perspective_mode),
    .width_eff        (width_eff),
    .height_eff       (height_eff),
    .sq_full          (sq_full),
    .sq_push          (sq_push),
    .sq_entry         (sq_entry)
  );

  tsr_span_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (sq_push),
    .wr_data (sq_entry),
    .rd      (sq_pop),
    .full    (sq_full),
    .empty   (sq_empty),
    .head    (sq_head)
  );

  // The back computes the span steps, walks the pixels and owns the depth buffer.
  tsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .width_eff (width_eff),
    .sq_empty  (sq_empty),
    .sq_head   (sq_head),
    .sq_pop    (sq_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .res_head  (res_head)
  );

  assign pixel_x      = res_head.x;
  assign pixel_y      = res_head.y;
  assign tex_u        = res_head.u;
  assign tex_v        = res_head.v;
  assign pixel_depth  = res_head.depth;
  assign write_enable = res_head.we;
  assign last_pixel   = res_head.last;

endmodule
`default_nettype wire

### rtl/tsr_divider.sv
`default_nettype none
module tsr_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsr_pkg::div_req_t req,
  output tsr_pkg::div_rsp_t      rsp
);

  localparam logic [5:0] LONG_STEPS  = 6'd48;
  localparam logic [5:0] SHORT_STEPS = 6'd33;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [47:0] q;
  logic [31:0] rem;
  logic [31:0] den_mag;
  logic        neg;
  logic        sat;
  logic        den_zero;
  logic        num_neg;
  logic        num_zero;

  logic [tsr_pkg::DIV_NUM_W-1:0] num_abs;
  logic [31:0]                   den_abs;
  logic [32:0]                   rem_sh;
  logic                          ge;
  logic [32:0]                   rem_sub;
  logic signed [tsr_pkg::DIV_NUM_W-1:0] q_signed;
  logic signed [63:0]            q_wide;

  assign num_abs = req.num[tsr_pkg::DIV_NUM_W-1] ? -req.num : req.num;
  assign den_abs = req.den[31] ? -req.den : req.den;
  assign rem_sh  = {rem, q[47]};
  assign ge      = rem_sh >= {1'b0, den_mag};
  assign rem_sub = rem_sh - {1'b0, den_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 6'd1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      q        <= req.short_mode ? {num_abs[32:0], 15'b0} : num_abs[47:0];
      cnt      <= req.short_mode ? SHORT_STEPS : LONG_STEPS;
      rem      <= '0;
      den_mag  <= den_abs;
      neg      <= req.num[tsr_pkg::DIV_NUM_W-1] ^ req.den[31];
      sat      <= req.sat;
      den_zero <= (req.den == '0);
      num_neg  <= req.num[tsr_pkg::DIV_NUM_W-1];
      num_zero <= (req.num == '0);
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      q   <= {q[46:0], ge};
      cnt <= cnt - 6'd1;
    end
  end

  assign q_signed = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign q_wide   = {{(64-tsr_pkg::DIV_NUM_W){q_signed[tsr_pkg::DIV_NUM_W-1]}}, q_signed};

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    if (den_zero) begin
      priority if (num_zero) begin
        rsp.quot = '0;
      end else if (num_neg) begin
        rsp.quot = tsr_pkg::SAT_LO[31:0];
      end else begin
        rsp.quot = tsr_pkg::SAT_HI[31:0];
      end
    end else if (sat) begin
      rsp.quot = tsr_pkg::sat32(q_wide);
    end else begin
      rsp.quot = q_wide[31:0];
    end
  end

endmodule
`default_nettype wire

### rtl/tsr_front.sv
`default_nettype none
module tsr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               hold,
  input  wire logic signed [15:0] row,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] start_depth,
  input  wire logic signed [31:0] end_depth,
  input  wire logic signed [31:0] start_u_over_z,
  input  wire logic signed [31:0] end_u_over_z,
  input  wire logic signed [31:0] start_v_over_z,
  input  wire logic signed [31:0] end_v_over_z,
  input  wire logic signed [31:0] start_inv_z,
  input  wire logic signed [31:0] end_inv_z,
  input  wire logic               perspective_mode,
  input  wire logic [6:0]         width_eff,
  input  wire logic [6:0]         height_eff,
  input  wire logic               sq_full,
  output logic                    sq_push,
  output tsr_pkg::span_t          sq_entry
);

  typedef struct packed {
    logic signed [15:0] row;
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] z0;
    logic signed [31:0] z1;
    logic signed [31:0] uz0;
    logic signed [31:0] uz1;
    logic signed [31:0] vz0;
    logic signed [31:0] vz1;
    logic signed [31:0] iz0;
    logic signed [31:0] iz1;
    logic               persp;
  } raw_t;

  logic stg_valid;
  raw_t stg;

  logic               swap;
  logic signed [31:0] xl;
  logic signed [31:0] xr;
  logic signed [32:0] ceil_sum;
  logic signed [16:0] xa_raw;
  logic signed [16:0] xb_raw;
  logic signed [16:0] wm1;
  logic signed [16:0] xa_c;
  logic signed [16:0] xb_c;
  logic signed [16:0] n_full;
  logic               row_bad;
  logic               reject;
  logic               adv;
  logic               accept;

  assign swap     = stg.x0 > stg.x1;
  assign xl       = swap ? stg.x1 : stg.x0;
  assign xr       = swap ? stg.x0 : stg.x1;
  // Ceiling of the left end and floor of the right end, both exact.
  assign ceil_sum = {xl[31], xl} + 33'sh0_0000_FFFF;
  assign xa_raw   = ceil_sum[32:16];
  assign xb_raw   = {xr[31], xr[31:16]};
  assign wm1      = $signed({10'b0, width_eff}) - 17'sd1;
  assign xa_c     = xa_raw[16] ? 17'sd0 : xa_raw;
  assign xb_c     = (xb_raw > wm1) ? wm1 : xb_raw;
  assign n_full   = xb_c - xa_c + 17'sd1;
  assign row_bad  = stg.row[15] || ({1'b0, stg.row[14:0]} >= {9'b0, height_eff});
  assign reject   = row_bad || (xa_c > xb_c);

  assign adv     = stg_valid && (reject || !sq_full);
  assign sq_push = stg_valid && !reject && !sq_full;
  assign full    = hold || (stg_valid && !adv);
  assign accept  = push && !full;

  always_comb begin
    sq_entry.row   = stg.row[5:0];
    sq_entry.xa    = xa_c[5:0];
    sq_entry.n     = n_full[6:0];
    sq_entry.persp = stg.persp;
    sq_entry.z0    = swap ? stg.z1 : stg.z0;
    sq_entry.z1    = swap ? stg.z0 : stg.z1;
    sq_entry.uz0   = swap ? stg.uz1 : stg.uz0;
    sq_entry.uz1   = swap ? stg.uz0 : stg.uz1;
    sq_entry.vz0   = swap ? stg.vz1 : stg.vz0;
    sq_entry.vz1   = swap ? stg.vz0 : stg.vz1;
    sq_entry.iz0   = swap ? stg.iz1 : stg.iz0;
    sq_entry.iz1   = swap ? stg.iz0 : stg.iz1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (adv) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg.row   <= row;
      stg.x0    <= start_x;
      stg.x1    <= end_x;
      stg.z0    <= start_depth;
      stg.z1    <= end_depth;
      stg.uz0   <= start_u_over_z;
      stg.uz1   <= end_u_over_z;
      stg.vz0   <= start_v_over_z;
      stg.vz1   <= end_v_over_z;
      stg.iz0   <= start_inv_z;
      stg.iz1   <= end_inv_z;
      stg.persp <= perspective_mode;
    end
  end

endmodule
`default_nettype wire

### rtl/tsr_span_queue.sv
`default_nettype none
module tsr_span_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire tsr_pkg::span_t wr_data,
  input  wire logic           rd,
  output logic                full,
  output logic                empty,
  output tsr_pkg::span_t      head
);

  tsr_pkg::span_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp <= ~wp;
      end
      if (rd && !empty) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      q[wp] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/tsr_back.sv
`default_nettype none
`include "textured_span_rasterizer_unit_defines.svh"
module tsr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [6:0]     width_eff,
  input  wire logic           sq_empty,
  input  wire tsr_pkg::span_t sq_head,
  output logic                sq_pop,
  output logic                clearing,
  input  wire logic           pop,
  output logic                empty,
  output tsr_pkg::pixel_t     res_head
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_PIX    = 4'd4;
  localparam logic [3:0] S_RWAIT  = 4'd5;
  localparam logic [3:0] S_MULU   = 4'd6;
  localparam logic [3:0] S_MULV   = 4'd7;
  localparam logic [3:0] S_TEST   = 4'd8;

  // Setup jobs. In perspective mode the second-end u job computes the 1/z step.
  localparam logic [2:0] JOB_Z_STEP   = 3'd0;
  localparam logic [2:0] JOB_U_FIRST  = 3'd1;
  localparam logic [2:0] JOB_V_FIRST  = 3'd2;
  localparam logic [2:0] JOB_U_SECOND = 3'd3;
  localparam logic [2:0] JOB_V_SECOND = 3'd4;
  localparam logic [2:0] JOB_U_STEP   = 3'd5;
  localparam logic [2:0] JOB_V_STEP   = 3'd6;

  localparam logic signed [tsr_pkg::DIV_NUM_W-1:0] RECIP_NUM =
    tsr_pkg::DIV_NUM_W'(64'sd1 <<< (2 * tsr_pkg::FRAC_BITS));

  logic [3:0]         state;
  logic [2:0]         job;
  tsr_pkg::span_t     cur;
  logic signed [31:0] acc_z, acc_u, acc_v, acc_i;
  logic signed [31:0] step_z, step_u, step_v, step_i;
  logic [5:0]         col;
  logic [6:0]         remaining;
  logic signed [31:0] recip;
  logic signed [63:0] prod;
  logic signed [31:0] u_res;
  logic [tsr_pkg::ADDR_W-1:0] clr_addr;
  logic signed [31:0] rd_data;
  logic signed [31:0] mem [tsr_pkg::STORE_DEPTH];

  tsr_pkg::div_req_t div_req;
  tsr_pkg::div_rsp_t div_rsp;

  tsr_pkg::pixel_t res_q [2];
  logic            res_wp;
  logic            res_rp;
  logic [1:0]      res_count;
  logic            res_push;
  logic            res_pop;

  logic [12:0]                row_off;
  logic [12:0]                addr_sum;
  logic [tsr_pkg::ADDR_W-1:0] pix_addr;
  logic                       pass;
  logic                       mem_we;
  logic [tsr_pkg::ADDR_W-1:0] mem_waddr;
  logic signed [31:0]         mem_wdata;
  logic                       mem_re;
  logic [2:0]                 last_job;
  logic signed [31:0]         v_now;
  tsr_pkg::pixel_t            pix;

  function automatic logic signed [tsr_pkg::DIV_NUM_W-1:0] sub_ext(
    input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return {{(tsr_pkg::DIV_NUM_W-33){d[32]}}, d};
  endfunction

  function automatic logic signed [tsr_pkg::DIV_NUM_W-1:0] shl_ext(
    input logic signed [31:0] a);
    return {{(tsr_pkg::DIV_NUM_W-32-tsr_pkg::FRAC_BITS){a[31]}}, a,
            {tsr_pkg::FRAC_BITS{1'b0}}};
  endfunction

  tsr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign row_off  = {7'b0, cur.row} * {6'b0, width_eff};
  assign addr_sum = row_off + {7'b0, col};
  assign pix_addr = addr_sum[tsr_pkg::ADDR_W-1:0];

  assign clearing = (state == S_CLEAR);
  assign sq_pop   = (state == S_IDLE) && !sq_empty;
  assign last_job = cur.persp ? JOB_U_SECOND : JOB_V_STEP;
  assign pass     = (acc_z > 32'sd0) && (acc_z < rd_data);
  assign v_now    = tsr_pkg::sat32(prod >>> tsr_pkg::FRAC_BITS);

  assign res_push = (state == S_TEST) && (res_count != 2'd2);
  assign res_pop  = pop && !empty;
  assign empty    = (res_count == 2'd0);
  assign res_head = res_q[res_rp];

  always_comb begin
    pix.x     = col;
    pix.y     = cur.row;
    pix.u     = cur.persp ? u_res : acc_u;
    pix.v     = cur.persp ? v_now : acc_v;
    pix.depth = acc_z;
    pix.we    = pass;
    pix.last  = (remaining == 7'd1);
  end

  always_comb begin
    mem_we    = clearing || (res_push && pass);
    mem_waddr = clearing ? clr_addr : pix_addr;
    mem_wdata = clearing ? tsr_pkg::FAR_DEPTH : acc_z;
    mem_re    = (state == S_PIX);
  end

  always_comb begin
    div_req.start      = (state == S_DSTART) || ((state == S_PIX) && cur.persp);
    div_req.num        = '0;
    div_req.den        = {25'b0, cur.n};
    div_req.short_mode = 1'b1;
    div_req.sat        = 1'b0;
    if (state == S_PIX) begin
      div_req.num = RECIP_NUM;
      div_req.den = acc_i;
      div_req.sat = 1'b1;
    end else begin
      unique case (job)
        JOB_Z_STEP: begin
          div_req.num = sub_ext(cur.z1, cur.z0);
        end
        JOB_U_FIRST: begin
          if (cur.persp) begin
            div_req.num = sub_ext(cur.uz1, cur.uz0);
          end else begin
            div_req.num        = shl_ext(cur.uz0);
            div_req.den        = cur.iz0;
            div_req.short_mode = 1'b0;
            div_req.sat        = 1'b1;
          end
        end
        JOB_V_FIRST: begin
          if (cur.persp) begin
            div_req.num = sub_ext(cur.vz1, cur.vz0);
          end else begin
            div_req.num        = shl_ext(cur.vz0);
            div_req.den        = cur.iz0;
            div_req.short_mode = 1'b0;
            div_req.sat        = 1'b1;
          end
        end
        JOB_U_SECOND: begin
          if (cur.persp) begin
            div_req.num = sub_ext(cur.iz1, cur.iz0);
          end else begin
            div_req.num        = shl_ext(cur.uz1);
            div_req.den        = cur.iz1;
            div_req.short_mode = 1'b0;
            div_req.sat        = 1'b1;
          end
        end
        JOB_V_SECOND: begin
          div_req.num        = shl_ext(cur.vz1);
          div_req.den        = cur.iz1;
          div_req.short_mode = 1'b0;
          div_req.sat        = 1'b1;
        end
        JOB_U_STEP: begin
          div_req.num = sub_ext(step_u, acc_u);
        end
        JOB_V_STEP: begin
          div_req.num = sub_ext(step_v, acc_v);
        end
        default: begin
          div_req.num = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {tsr_pkg::ADDR_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!sq_empty) begin
            cur       <= sq_head;
            acc_z     <= sq_head.z0;
            acc_u     <= sq_head.uz0;
            acc_v     <= sq_head.vz0;
            acc_i     <= sq_head.iz0;
            col       <= sq_head.xa;
            remaining <= sq_head.n;
            job       <= JOB_Z_STEP;
            state     <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            unique case (job)
              JOB_Z_STEP:   step_z <= div_rsp.quot;
              JOB_U_FIRST:  if (cur.persp) step_u <= div_rsp.quot;
                            else acc_u <= div_rsp.quot;
              JOB_V_FIRST:  if (cur.persp) step_v <= div_rsp.quot;
                            else acc_v <= div_rsp.quot;
              JOB_U_SECOND: if (cur.persp) step_i <= div_rsp.quot;
                            else step_u <= div_rsp.quot;
              JOB_V_SECOND: step_v <= div_rsp.quot;
              JOB_U_STEP:   step_u <= div_rsp.quot;
              JOB_V_STEP:   step_v <= div_rsp.quot;
              default:      step_z <= div_rsp.quot;
            endcase
            if (job == last_job) begin
              state <= S_PIX;
            end else begin
              job   <= job + 3'd1;
              state <= S_DSTART;
            end
          end
        end
        S_PIX: begin
          state <= cur.persp ? S_RWAIT : S_TEST;
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            recip <= div_rsp.quot;
            state <= S_MULU;
          end
        end
        S_MULU: begin
          prod  <= acc_u * recip;
          state <= S_MULV;
        end
        S_MULV: begin
          u_res <= tsr_pkg::sat32(prod >>> tsr_pkg::FRAC_BITS);
          prod  <= acc_v * recip;
          state <= S_TEST;
        end
        S_TEST: begin
          if (res_push) begin
            acc_z     <= acc_z + step_z;
            acc_u     <= acc_u + step_u;
            acc_v     <= acc_v + step_v;
            acc_i     <= acc_i + step_i;
            col       <= col + 6'd1;
            remaining <= remaining - 7'd1;
            state     <= (remaining == 7'd1) ? S_IDLE : S_PIX;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp    <= 1'b0;
      res_rp    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push) begin
        res_wp <= ~res_wp;
      end
      if (res_pop) begin
        res_rp <= ~res_rp;
      end
      res_count <= res_count + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[res_wp] <= pix;
    end
  end

  `TSR_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `TSR_ASSERT(a_no_pop_clear, clearing |-> !sq_pop, "span taken during depth clear")
  `TSR_ASSERT(a_res_bound, res_count != 2'd3, "result queue overflow")
  `TSR_ASSERT(a_walk_count, (state == S_TEST) |-> (remaining != 7'd0), "pixel walk past span end")
  `TSR_ASSERT_ALWAYS(a_rst_clear, rst |=> clearing, "depth clear not started by reset")

endmodule
`default_nettype wire
